[hw/rtl/rtas_pkg.sv]
// ----------------------------------------------------------------------------
// rtas_pkg
// Shared types and constants for the retransmit-table ARQ sender core.
// ----------------------------------------------------------------------------
package rtas_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [19:0] TIMEOUT_RESET = 20'd2000;
   localparam logic [15:0] SEQ_RESET     = 16'd1;

   // operation codes of a request item
   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_ACK  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_SCAN = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_NEW         = 3'd0;
   localparam logic [2:0] KIND_RETX        = 3'd1;
   localparam logic [2:0] KIND_ACK_OK      = 3'd2;
   localparam logic [2:0] KIND_ACK_UNKNOWN = 3'd3;
   localparam logic [2:0] KIND_FULL        = 3'd4;
   localparam logic [2:0] KIND_NOTHING     = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data_byte;
      logic [7:0]  dest_id;
      logic [15:0] ack_seq;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  frame_byte;
      logic [7:0]  frame_dest;
      logic [15:0] frame_seq;
      logic        last;
   } rsp_item_type;

   // write command into the slot table
   typedef struct packed {
      logic             fill;
      logic             free;
      logic             restamp;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data_byte;
      logic [7:0]       dest_id;
      logic [15:0]      seq;
      logic [31:0]      stamp;
   } tbl_wr_type;

   // one slot as seen by the sequencer
   typedef struct packed {
      logic        valid;
      logic [7:0]  data_byte;
      logic [7:0]  dest_id;
      logic [15:0] seq;
      logic [31:0] stamp;
   } tbl_entry_type;

endpackage

[hw/rtl/rtas_table.sv]
// ----------------------------------------------------------------------------
// rtas_table
// Slot table of unacknowledged items: valid bits, payload, sequence, stamp.
// ----------------------------------------------------------------------------
module rtas_table
   import rtas_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   input  tbl_wr_type       wr,
   output tbl_entry_type    rd_entry
);

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [7:0]             byte_ff  [TABLE_DEPTH];
   logic [7:0]             dest_ff  [TABLE_DEPTH];
   logic [15:0]            seq_ff   [TABLE_DEPTH];
   logic [31:0]            stamp_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.fill) begin
         valid_ff[wr.idx] <= 1'b1;
      end else if (wr.free) begin
         valid_ff[wr.idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.fill) begin
         byte_ff[wr.idx] <= wr.data_byte;
         dest_ff[wr.idx] <= wr.dest_id;
         seq_ff[wr.idx]  <= wr.seq;
      end
      if (wr.fill || wr.restamp) begin
         stamp_ff[wr.idx] <= wr.stamp;
      end
   end

   assign rd_entry.valid     = valid_ff[rd_idx];
   assign rd_entry.data_byte = byte_ff[rd_idx];
   assign rd_entry.dest_id   = dest_ff[rd_idx];
   assign rd_entry.seq       = seq_ff[rd_idx];
   assign rd_entry.stamp     = stamp_ff[rd_idx];

endmodule

[hw/rtl/retransmit_table_arq_sender_core.sv]
// ----------------------------------------------------------------------------
// retransmit_table_arq_sender_core
// Sender side of a reliable-datagram scheme: numbers outgoing bytes, keeps
// them in a table until acknowledged, and retransmits entries that time out.
// ----------------------------------------------------------------------------
//
//   channel   ports                        handshake
//   -------   --------------------------   ------------------------------
//   request   start, busy, req_item        taken when start & !busy
//   result    rsp_strobe, rsp_item         one cycle per item, no stall
//   config    csr_wr_en, csr_wr_data       written when csr_wr_en is high
//
// A tick is handled in ST_IDLE itself. Send and ack walk the slot table one slot
// per cycle and stop at the first hit: a free slot for send, a sequence match
// from the shared compare unit for ack. A scan walks all TABLE_DEPTH slots, then
// passes through ST_FINISH to flag the final retransmit or report nothing due.
// Results appear on the cycle after the one that decides them.
// Reset clears the valid bits at once; no clearing pass is needed.
// The receiver cannot stall: every result is driven for exactly one cycle.
// ----------------------------------------------------------------------------
module retransmit_table_arq_sender_core
   import rtas_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   // result channel
   output logic         rsp_strobe,
   output rsp_item_type rsp_item,
   // configuration
   input  logic         csr_wr_en,
   input  logic [19:0]  csr_wr_data
);

   state_type     state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   req_item_type  req_ff, req_in;
   logic [15:0]   next_seq_ff, next_seq_in;
   logic [31:0]   now_ff, now_in;
   logic [19:0]   timeout_ff;
   logic          pend_valid_ff, pend_valid_in;
   rsp_item_type  pend_ff, pend_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type  rsp_ff, rsp_in;

   tbl_wr_type    tbl_wr;
   tbl_entry_type entry;

   logic [31:0]   age;
   logic          due;
   logic          match;
   logic          last_slot;

   function automatic rsp_item_type make_rsp(input logic [2:0]  kind,
                                             input logic [7:0]  fbyte,
                                             input logic [7:0]  fdest,
                                             input logic [15:0] fseq,
                                             input logic        flast);
      rsp_item_type r;
      r.kind       = kind;
      r.frame_byte = fbyte;
      r.frame_dest = fdest;
      r.frame_seq  = fseq;
      r.last       = flast;
      return r;
   endfunction

   rtas_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .wr       (tbl_wr),
      .rd_entry (entry)
   );

   // shared compare unit: age test for scan, sequence match for ack
   assign age       = now_ff - entry.stamp;
   assign due       = entry.valid && (age > {12'd0, timeout_ff});
   assign match     = entry.valid && (entry.seq == req_ff.ack_seq);
   assign last_slot = (idx_ff == LAST_IDX);

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      next_seq_in   = next_seq_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      tbl_wr        = '0;
      tbl_wr.idx    = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req_item;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               if (req_item.op == OP_TICK) begin
                  // advance time and report nothing
                  now_in        = now_ff + 32'd1;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = make_rsp(KIND_NOTHING, 8'd0, 8'd0, 16'd0, 1'b1);
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            case (req_ff.op)
               OP_SEND: begin
                  if (!entry.valid) begin
                     // file the byte in the first free slot
                     tbl_wr.fill      = 1'b1;
                     tbl_wr.data_byte = req_ff.data_byte;
                     tbl_wr.dest_id   = req_ff.dest_id;
                     tbl_wr.seq       = next_seq_ff;
                     tbl_wr.stamp     = now_ff;
                     next_seq_in      = next_seq_ff + 16'd1;
                     rsp_strobe_in    = 1'b1;
                     rsp_in           = make_rsp(KIND_NEW, req_ff.data_byte,
                                                 req_ff.dest_id, next_seq_ff, 1'b1);
                     state_in         = ST_IDLE;
                  end else if (last_slot) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = make_rsp(KIND_FULL, req_ff.data_byte,
                                              req_ff.dest_id, 16'd0, 1'b1);
                     state_in      = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end

               OP_ACK: begin
                  if (match) begin
                     // drop the acknowledged entry
                     tbl_wr.free   = 1'b1;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = make_rsp(KIND_ACK_OK, entry.data_byte,
                                              entry.dest_id, req_ff.ack_seq, 1'b1);
                     state_in      = ST_IDLE;
                  end else if (last_slot) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = make_rsp(KIND_ACK_UNKNOWN, 8'd0, 8'd0,
                                              req_ff.ack_seq, 1'b1);
                     state_in      = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end

               OP_SCAN: begin
                  if (due) begin
                     // restamp and hold this frame until we know if it is last
                     tbl_wr.restamp = 1'b1;
                     tbl_wr.stamp   = now_ff;
                     if (pend_valid_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = pend_ff;
                     end
                     pend_valid_in = 1'b1;
                     pend_in       = make_rsp(KIND_RETX, entry.data_byte,
                                              entry.dest_id, entry.seq, 1'b0);
                  end
                  if (last_slot) begin
                     state_in = ST_FINISH;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end

               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_FINISH: begin
            // flush the held frame as the final one, or report nothing due
            rsp_strobe_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in = make_rsp(KIND_NOTHING, 8'd0, 8'd0, 16'd0, 1'b1);
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_seq_ff   <= SEQ_RESET;
         now_ff        <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_seq_ff   <= next_seq_in;
         now_ff        <= now_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

endmodule

[sim/tb_retransmit_table_arq_sender_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_retransmit_table_arq_sender_core
// Self-checking bench for the ARQ sender core. A short table of directed
// items covers the boundaries: empty table, unknown acks, table full, first
// and last byte values. Randomized phases under several retransmit timeouts
// follow, with a short back-to-back send/ack march in between. A behavioral
// model of the slot table predicts every result, and each strobed result is
// compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_retransmit_table_arq_sender_core
   import rtas_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MARCH_PAIRS    = 8;

   // one row of the directed table; pinned rows carry a hand-typed result
   typedef struct packed {
      req_item_type req;
      logic         pinned;
      rsp_item_type rsp;
   } dir_row_type;

   localparam int DIR_ROWS = 25;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   logic         csr_wr_en;
   logic [19:0]  csr_wr_data;

   retransmit_table_arq_sender_core DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // Shadow copy of the sender: slot table, sequence counter, clock, timeout
   // ------------------------------------------------------------------------
   logic        tab_valid [TABLE_DEPTH];
   logic [7:0]  tab_byte  [TABLE_DEPTH];
   logic [7:0]  tab_dest  [TABLE_DEPTH];
   logic [15:0] tab_seq   [TABLE_DEPTH];
   logic [31:0] tab_stamp [TABLE_DEPTH];
   logic [15:0] seq_next;
   logic [31:0] tick_now;
   logic [19:0] retx_timeout;

   // frames and statuses still owed by the core, oldest first
   rsp_item_type frames_due [$];

   // a directed row with a typed result overrides the shadow's output
   logic         row_pinned;
   rsp_item_type row_rsp;

   logic gaps_on;
   int   quiet_cycles;
   int   n_mismatch;
   int   n_items, n_send, n_ack, n_tick, n_scan;
   int   n_results, n_full, n_retx, n_ack_hit, max_burst;
   logic seq_wrapped;

   dir_row_type dir_table [DIR_ROWS];

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Shadow model: apply one accepted item, queue the results it causes
   // ------------------------------------------------------------------------
   task automatic arq_predict(input req_item_type it);
      rsp_item_type outs [$];
      rsp_item_type r;
      rsp_item_type held;
      logic [31:0]  age;
      logic         hit;
      logic         have_held;
      int           burst;
      hit       = 1'b0;
      have_held = 1'b0;
      burst     = 0;
      r         = '0;
      held      = '0;
      n_items++;
      case (it.op)
         OP_SEND: begin
            n_send++;
            // file the byte in the lowest free slot
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!hit && !tab_valid[i]) begin
                  hit          = 1'b1;
                  tab_valid[i] = 1'b1;
                  tab_byte[i]  = it.data_byte;
                  tab_dest[i]  = it.dest_id;
                  tab_seq[i]   = seq_next;
                  tab_stamp[i] = tick_now;
                  r = '{KIND_NEW, it.data_byte, it.dest_id, seq_next, 1'b1};
                  if (seq_next == 16'd0) seq_wrapped = 1'b1;
                  seq_next = seq_next + 16'd1;
               end
            end
            // refuse without consuming a sequence number
            if (!hit) begin
               n_full++;
               r = '{KIND_FULL, it.data_byte, it.dest_id, 16'd0, 1'b1};
            end
            outs.push_back(r);
         end
         OP_ACK: begin
            n_ack++;
            // free the lowest slot holding that sequence number, if any
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!hit && tab_valid[i] && tab_seq[i] == it.ack_seq) begin
                  hit          = 1'b1;
                  tab_valid[i] = 1'b0;
                  r = '{KIND_ACK_OK, tab_byte[i], tab_dest[i], it.ack_seq, 1'b1};
               end
            end
            if (hit) begin
               n_ack_hit++;
            end else begin
               r = '{KIND_ACK_UNKNOWN, 8'd0, 8'd0, it.ack_seq, 1'b1};
            end
            outs.push_back(r);
         end
         OP_TICK: begin
            n_tick++;
            tick_now = tick_now + 32'd1;
            r = '{KIND_NOTHING, 8'd0, 8'd0, 16'd0, 1'b1};
            outs.push_back(r);
         end
         OP_SCAN: begin
            n_scan++;
            // retransmit and restamp every overdue entry, in slot order;
            // hold each frame back one step so the final one can be flagged
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (tab_valid[i]) begin
                  age = tick_now - tab_stamp[i];
                  if (age > {12'd0, retx_timeout}) begin
                     tab_stamp[i] = tick_now;
                     if (have_held) outs.push_back(held);
                     held = '{KIND_RETX, tab_byte[i], tab_dest[i], tab_seq[i], 1'b0};
                     have_held = 1'b1;
                     burst++;
                     n_retx++;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               outs.push_back(held);
            end else begin
               r = '{KIND_NOTHING, 8'd0, 8'd0, 16'd0, 1'b1};
               outs.push_back(r);
            end
            if (burst > max_burst) max_burst = burst;
         end
      endcase
      if (row_pinned) begin
         frames_due.push_back(row_rsp);
      end else begin
         foreach (outs[k]) frames_due.push_back(outs[k]);
      end
   endtask

   task automatic log_mismatch(input string what);
      n_mismatch++;
      if (n_mismatch <= 10) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // compare one strobed result against the oldest prediction
   task automatic check_frame(input rsp_item_type got);
      rsp_item_type want;
      n_results++;
      if (frames_due.size() == 0) begin
         log_mismatch($sformatf("unexpected result kind=%0d byte=%02h dest=%02h seq=%0d",
                                got.kind, got.frame_byte, got.frame_dest, got.frame_seq));
      end else begin
         want = frames_due.pop_front();
         if (got.kind !== want.kind || got.frame_byte !== want.frame_byte ||
             got.frame_dest !== want.frame_dest || got.frame_seq !== want.frame_seq ||
             got.last !== want.last) begin
            log_mismatch($sformatf(
               {"exp kind=%0d byte=%02h dest=%02h seq=%0d last=%0d / ",
                "got kind=%0d byte=%02h dest=%02h seq=%0d last=%0d"},
               want.kind, want.frame_byte, want.frame_dest, want.frame_seq, want.last,
               got.kind, got.frame_byte, got.frame_dest, got.frame_seq, got.last));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         // check results first; a result never belongs to the item taken now
         if (rsp_strobe === 1'b1) check_frame(rsp_item);
         if (start === 1'b1 && busy === 1'b0) arq_predict(req_item);
         if (rsp_strobe === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long
   // ------------------------------------------------------------------------
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("[%0t] watchdog: no item or result for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, frames_due.size());
      $display("tb_retransmit_table_arq_sender_core: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver helpers; each one is entered and left at a falling edge
   // ------------------------------------------------------------------------

   // offer one item, optionally after a random gap, and hold it until taken;
   // start stays high on return so back-to-back items never glitch it
   task automatic issue(input req_item_type it);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_item = it;
      start    = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   // drop start, then wait for every owed result plus the scan latency
   task automatic settle();
      start = 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 4) @(posedge clock);
      @(negedge clock);
   endtask

   // write the timeout register while the core is idle
   task automatic set_timeout(input logic [19:0] value);
      settle();
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(posedge clock);
      retx_timeout = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic req_item_type make_item(input logic [1:0] op, input logic [7:0] b,
                                              input logic [7:0] d, input logic [15:0] a);
      req_item_type it;
      it.op        = op;
      it.data_byte = b;
      it.dest_id   = d;
      it.ack_seq   = a;
      return it;
   endfunction

   function automatic dir_row_type row(input logic [1:0] op, input logic [7:0] b,
                                       input logic [7:0] d, input logic [15:0] a,
                                       input logic pin, input logic [2:0] k,
                                       input logic [7:0] fb, input logic [7:0] fd,
                                       input logic [15:0] fs);
      dir_row_type rw;
      rw.req    = make_item(op, b, d, a);
      rw.pinned = pin;
      rw.rsp    = '{k, fb, fd, fs, 1'b1};
      return rw;
   endfunction

   // mostly well-formed traffic: acks usually name an outstanding frame
   function automatic req_item_type random_request();
      req_item_type it;
      logic [31:0]  r;
      int           pick;
      int           first;
      int           idx;
      logic         found;
      r     = $urandom;
      pick  = $urandom_range(0, 99);
      found = 1'b0;
      it.data_byte = r[7:0];
      it.dest_id   = r[15:8];
      it.ack_seq   = r[31:16];
      if (pick < 30) begin
         it.op = OP_SEND;
      end else if (pick < 63) begin
         it.op = OP_ACK;
         if (pick < 55) begin
            first = $urandom_range(0, TABLE_DEPTH - 1);
            for (int k = 0; k < TABLE_DEPTH; k++) begin
               idx = (first + k) % TABLE_DEPTH;
               if (!found && tab_valid[idx]) begin
                  found      = 1'b1;
                  it.ack_seq = tab_seq[idx];
               end
            end
         end
      end else if (pick < 85) begin
         it.op = OP_TICK;
      end else begin
         it.op = OP_SCAN;
      end
      return it;
   endfunction

   task automatic random_phase(input int count);
      for (int k = 0; k < count; k++) issue(random_request());
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 20'd0;
      row_pinned  = 1'b0;
      row_rsp     = '0;
      gaps_on     = 1'b1;
      n_mismatch  = 0;
      n_items = 0; n_send = 0; n_ack = 0; n_tick = 0; n_scan = 0;
      n_results = 0; n_full = 0; n_retx = 0; n_ack_hit = 0; max_burst = 0;
      seq_wrapped = 1'b0;

      // shadow state after reset
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tab_valid[i] = 1'b0;
         tab_byte[i]  = 8'd0;
         tab_dest[i]  = 8'd0;
         tab_seq[i]   = 16'd0;
         tab_stamp[i] = 32'd0;
      end
      seq_next     = SEQ_RESET;
      tick_now     = 32'd0;
      retx_timeout = TIMEOUT_RESET;

      // directed table: empty table, unknown acks at both ends, fill the
      // table with all-zero and all-one bytes among others, refuse when full,
      // then a matched ack, the same ack again, refill and a quiet scan
      dir_table = '{
         row(OP_SCAN, 8'h00, 8'h00, 16'h0000, 1'b1, KIND_NOTHING, 8'h00, 8'h00, 16'd0),
         row(OP_ACK,  8'h00, 8'h00, 16'h0000, 1'b1, KIND_ACK_UNKNOWN, 8'h00, 8'h00, 16'h0000),
         row(OP_ACK,  8'hFF, 8'hFF, 16'hFFFF, 1'b1, KIND_ACK_UNKNOWN, 8'h00, 8'h00, 16'hFFFF),
         row(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, KIND_NOTHING, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h00, 8'h00, 16'hFFFF, 1'b1, KIND_NEW, 8'h00, 8'h00, 16'd1),
         row(OP_SEND, 8'hFF, 8'hFF, 16'h0000, 1'b1, KIND_NEW, 8'hFF, 8'hFF, 16'd2),
         row(OP_SEND, 8'h01, 8'h80, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h02, 8'h40, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h04, 8'h20, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h08, 8'h10, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h10, 8'h08, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h20, 8'h04, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h40, 8'h02, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h80, 8'h01, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h5A, 8'hA5, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h3C, 8'hC3, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h0F, 8'hF0, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'hF0, 8'h0F, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h66, 8'h99, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'h7E, 8'h81, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SEND, 8'hC3, 8'h3C, 16'h0000, 1'b1, KIND_FULL, 8'hC3, 8'h3C, 16'd0),
         row(OP_ACK,  8'h00, 8'h00, 16'd2,    1'b1, KIND_ACK_OK, 8'hFF, 8'hFF, 16'd2),
         row(OP_ACK,  8'h00, 8'h00, 16'd2,    1'b1, KIND_ACK_UNKNOWN, 8'h00, 8'h00, 16'd2),
         row(OP_SEND, 8'hAA, 8'h55, 16'h0000, 1'b0, KIND_NEW, 8'h00, 8'h00, 16'd0),
         row(OP_SCAN, 8'h00, 8'h00, 16'h0000, 1'b1, KIND_NOTHING, 8'h00, 8'h00, 16'd0)
      };

      // hold reset, then release it on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         row_pinned = dir_table[i].pinned;
         row_rsp    = dir_table[i].rsp;
         issue(dir_table[i].req);
      end
      row_pinned = 1'b0;

      // timeout zero: one tick makes the whole full table overdue at once
      set_timeout(20'd0);
      issue(make_item(OP_TICK, 8'h00, 8'h00, 16'h0000));
      issue(make_item(OP_SCAN, 8'h00, 8'h00, 16'h0000));
      random_phase(70);

      // smallest nonzero timeout
      set_timeout(20'd1);
      gaps_on = ($urandom_range(0, 3) != 0);
      random_phase(70);

      // empty the table, then run a short back-to-back send/ack march
      settle();
      gaps_on = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tab_valid[i]) issue(make_item(OP_ACK, 8'h00, 8'h00, tab_seq[i]));
      end
      for (int k = 0; k < MARCH_PAIRS; k++) begin
         issue(make_item(OP_SEND, 8'($urandom), 8'($urandom), 16'($urandom)));
         issue(make_item(OP_ACK, 8'($urandom), 8'($urandom), seq_next - 16'd1));
      end

      // largest timeout: nothing ever comes due
      set_timeout(20'hFFFFF);
      gaps_on = ($urandom_range(0, 3) != 0);
      random_phase(70);

      set_timeout(20'($urandom_range(2, 12)));
      gaps_on = 1'b1;
      random_phase(80);

      // closing stretch runs back to back
      set_timeout(20'd3);
      gaps_on = 1'b0;
      random_phase(100);

      settle();

      $display("run: %0d items (%0d send, %0d ack, %0d tick, %0d scan), %0d results checked",
               n_items, n_send, n_ack, n_tick, n_scan, n_results);
      $display({"run: %0d acks matched, %0d refused sends, ",
                "%0d retransmits (max %0d per scan), seq wrap %0s"},
               n_ack_hit, n_full, n_retx, max_burst, seq_wrapped ? "seen" : "not seen");
      if (n_mismatch == 0) begin
         $display("tb_retransmit_table_arq_sender_core: PASS");
      end else begin
         $display("%0d mismatches in total", n_mismatch);
         $display("tb_retransmit_table_arq_sender_core: FAIL");
      end
      $finish;
   end

endmodule
